[rtl/spq_pkg.sv]
// spq_pkg: shared types and constants for the stable max-priority queue.
// No dependencies; every other file in rtl imports it.
package spq_pkg;

	localparam int CAPACITY = 64;
	localparam int TAG_BITS = 16;
	localparam int PRIO_W   = 32;
	localparam int IN_TAG_W = 16;
	localparam int OCC_W    = 7;
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef enum logic {
		ACT_INSERT = 1'b0,
		ACT_POP    = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_INSERTED = 2'd0,
		ST_POPPED   = 2'd1,
		ST_FULL     = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef struct packed {
		action_t                   action;
		logic signed [PRIO_W-1:0]  priority_req;
		logic [IN_TAG_W-1:0]       tag;
	} in_item_t;

	typedef struct packed {
		status_t                   status;
		logic [IN_TAG_W-1:0]       out_tag;
		logic signed [PRIO_W-1:0]  out_priority;
		logic [OCC_W-1:0]          occupancy;
	} out_item_t;

	typedef struct packed {
		logic signed [PRIO_W-1:0]  prio;
		logic [TAG_BITS-1:0]       tag;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   pop;
		entry_t fresh;
	} cell_ctl_t;

endpackage

[rtl/spq_if.sv]
// spq_in_if / spq_out_if: valid-ready channels carrying request and result items.
// Depends on spq_pkg for the payload types.
interface spq_in_if import spq_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface spq_out_if import spq_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/spq_cell.sv]
// spq_cell: one slot of the sorted shift chain; holds one entry and decides
// each cycle whether to hold, take the new entry, or take a neighbor's entry.
// Depends on spq_pkg.
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occupied,
	input  logic      prev_keep,
	input  entry_t    prev_e,
	input  entry_t    next_e,
	output entry_t    e,
	output logic      keep
);

	entry_t e_q;

	assign e    = e_q;
	assign keep = occupied && (e_q.prio >= ctl.fresh.prio);

	always_ff @(posedge clk) begin
		priority if (ctl.pop) begin
			e_q <= next_e;
		end else if (ctl.ins) begin
			if (!prev_keep) begin
				e_q <= prev_e;
			end else if (!keep) begin
				e_q <= ctl.fresh;
			end
		end else begin
			e_q <= e_q;
		end
	end

endmodule

[rtl/stable_max_priority_queue.sv]
// stable_max_priority_queue: top level; chain of spq_cell slots, fill count
// and registered result stage. Depends on spq_pkg, spq_if, spq_cell.
//
//   channel | dir | handshake         | payload
//   req     | in  | req.valid/ready   | action, priority_req, tag
//   rsp     | out | rsp.valid/ready   | status, out_tag, out_priority, occupancy
//
// All cells compare against the new priority at once and shift at the same edge;
// the result register is loaded at that edge too.
// A new request is taken whenever the result register is empty or being drained.
// A stalled rsp holds the result and blocks req. Reset clears the fill count and
// result valid; slot contents are not cleared, slots at or above the count are unused.
module stable_max_priority_queue import spq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	spq_in_if.sink     req,
	spq_out_if.source  rsp
);

	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                rsp_valid_q;
	out_item_t           rsp_data_q;
	out_item_t           rsp_data_d;
	logic                fire;
	logic                is_pop;
	logic                full;
	logic                empty;
	cell_ctl_t           ctl;
	entry_t              cell_e [CAPACITY];
	logic [CAPACITY-1:0] cell_keep;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;
	assign is_pop    = (req.data.action == ACT_POP);
	assign full      = (count_q == CNT_W'(CAPACITY));
	assign empty     = (count_q == '0);

	assign ctl.ins         = fire && !is_pop && !full;
	assign ctl.pop         = fire && is_pop && !empty;
	assign ctl.fresh.prio  = req.data.priority_req;
	assign ctl.fresh.tag   = TAG_BITS'(req.data.tag);

	genvar gi;
	generate
		for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
			entry_t prev_e;
			entry_t next_e;
			logic   prev_keep;

			if (gi == 0) begin : g_first
				assign prev_e    = ctl.fresh;
				assign prev_keep = 1'b1;
			end else begin : g_mid
				assign prev_e    = cell_e[gi-1];
				assign prev_keep = cell_keep[gi-1];
			end

			if (gi == CAPACITY - 1) begin : g_last
				assign next_e = cell_e[gi];
			end else begin : g_inner
				assign next_e = cell_e[gi+1];
			end

			spq_cell u_cell (
				.clk       (clk),
				.ctl       (ctl),
				.occupied  (count_q > CNT_W'(gi)),
				.prev_keep (prev_keep),
				.prev_e    (prev_e),
				.next_e    (next_e),
				.e         (cell_e[gi]),
				.keep      (cell_keep[gi])
			);
		end
	endgenerate

	always_comb begin
		count_d                 = count_q;
		rsp_data_d.out_tag      = '0;
		rsp_data_d.out_priority = '0;
		if (is_pop) begin
			if (empty) begin
				rsp_data_d.status = ST_EMPTY;
			end else begin
				rsp_data_d.status       = ST_POPPED;
				rsp_data_d.out_tag      = IN_TAG_W'(cell_e[0].tag);
				rsp_data_d.out_priority = cell_e[0].prio;
				count_d                 = count_q - CNT_W'(1);
			end
		end else begin
			if (full) begin
				rsp_data_d.status = ST_FULL;
			end else begin
				rsp_data_d.status = ST_INSERTED;
				count_d           = count_q + CNT_W'(1);
			end
		end
		rsp_data_d.occupancy = OCC_W'(count_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			rsp_data_q <= rsp_data_d;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

[test/spq_order_checker.sv]
// spq_order_checker: watches the request and result channels of the priority queue,
// keeps its own sorted copy of the store and checks every result in order.
// Depends on spq_pkg and the spq_in_if / spq_out_if interfaces.
module spq_order_checker import spq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	spq_in_if    req,
	spq_out_if   rsp,
	output int   mismatches,
	output int   outstanding,
	output int   served,
	output int   empties,
	output int   drops
);

	entry_t    sorted_entries[$];
	out_item_t due_results[$];
	out_item_t want;

	initial begin
		mismatches  = 0;
		outstanding = 0;
		served      = 0;
		empties     = 0;
		drops       = 0;
	end

	task automatic flag_mismatch(input string what, input longint got, input longint exp);
		$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, exp);
		mismatches++;
	endtask

	// Apply one request to the sorted store and return the result it must produce.
	function automatic out_item_t apply_request(input in_item_t r);
		out_item_t res;
		entry_t    e;
		int        pos;
		res = '0;
		if (r.action == ACT_POP) begin
			if (sorted_entries.size() == 0) begin
				res.status = ST_EMPTY;
			end else begin
				e = sorted_entries.pop_front();
				res.status       = ST_POPPED;
				res.out_tag      = IN_TAG_W'(e.tag);
				res.out_priority = e.prio;
			end
		end else if (sorted_entries.size() >= CAPACITY) begin
			res.status = ST_FULL;
		end else begin
			e.prio = r.priority_req;
			e.tag  = TAG_BITS'(r.tag);
			pos = 0;
			// go behind every entry of equal or higher priority
			while (pos < sorted_entries.size() &&
			       $signed(sorted_entries[pos].prio) >= $signed(e.prio))
				pos++;
			sorted_entries.insert(pos, e);
			res.status = ST_INSERTED;
		end
		res.occupancy = OCC_W'(sorted_entries.size());
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sorted_entries.delete();
			due_results.delete();
			outstanding = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (due_results.size() == 0) begin
					flag_mismatch("result with no request pending, status", rsp.data.status, 0);
				end else begin
					want = due_results.pop_front();
					if (rsp.data.status != want.status)
						flag_mismatch("status", rsp.data.status, want.status);
					if (rsp.data.out_tag != want.out_tag)
						flag_mismatch("out_tag", rsp.data.out_tag, want.out_tag);
					if (rsp.data.out_priority != want.out_priority)
						flag_mismatch("out_priority", rsp.data.out_priority, want.out_priority);
					if (rsp.data.occupancy != want.occupancy)
						flag_mismatch("occupancy", rsp.data.occupancy, want.occupancy);
					case (want.status)
						ST_POPPED: served++;
						ST_EMPTY:  empties++;
						ST_FULL:   drops++;
						default: ;
					endcase
				end
			end
			if (req.valid && req.ready)
				due_results.push_back(apply_request(req.data));
			outstanding = due_results.size();
		end
	end

endmodule

[test/tb_top.sv]
// tb_top: drives the priority queue with directed and random requests under bursty
// input and a stalling result side; spq_order_checker predicts and compares.
// Depends on spq_pkg, spq_if, stable_max_priority_queue and spq_order_checker.
module tb_top import spq_pkg::*;;

	logic clk;
	logic arst_n;
	int   mismatches, outstanding, served, empties, drops;
	int   burst_left;
	int   sent;
	int   cyc;
	int   stall_mode;

	spq_in_if  req ();
	spq_out_if rsp ();

	stable_max_priority_queue uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	spq_order_checker chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.mismatches  (mismatches),
		.outstanding (outstanding),
		.served      (served),
		.empties     (empties),
		.drops       (drops)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", outstanding);
		$display("== FAIL ==");
		$finish;
	end

	// result side: switch from time to time among stall patterns
	initial begin
		cyc = 0;
		stall_mode = 0;
	end
	always @(negedge clk) begin
		cyc <= cyc + 1;
		if (cyc % 150 == 0)
			stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: rsp.ready <= 1'b1;
			1: rsp.ready <= ($urandom_range(0, 3) != 0);
			2: rsp.ready <= ($urandom_range(0, 9) < 3);
			default: rsp.ready <= (cyc % 7 < 4);
		endcase
	end

	function automatic logic signed [PRIO_W-1:0] pick_priority();
		int kind;
		kind = $urandom_range(0, 9);
		if (kind < 5)
			return PRIO_W'($signed($urandom_range(0, 6)) - 3);
		if (kind < 8)
			return PRIO_W'($urandom);
		case ($urandom_range(0, 3))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'h0;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	function automatic in_item_t make_request(input bit pop);
		in_item_t it;
		it.action       = pop ? ACT_POP : ACT_INSERT;
		it.priority_req = pick_priority();
		it.tag          = IN_TAG_W'($urandom);
		return it;
	endfunction

	function automatic in_item_t fixed_request(input action_t act,
	                                           input logic [PRIO_W-1:0] prio,
	                                           input logic [IN_TAG_W-1:0] tag);
		in_item_t it;
		it.action       = act;
		it.priority_req = prio;
		it.tag          = tag;
		return it;
	endfunction

	task automatic push_request(input in_item_t it);
		@(negedge clk);
		req.valid <= 1'b1;
		req.data  <= it;
		do @(posedge clk); while (!req.ready);
	endtask

	// pace requests in bursts; a gap between bursts drops valid
	task automatic issue(input in_item_t it);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				@(negedge clk);
				req.valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
			burst_left = $urandom_range(1, 30);
		end
		push_request(it);
		burst_left--;
		sent++;
	endtask

	initial begin
		int mode, seg, pop_pct;
		arst_n     = 1'b0;
		req.valid  = 1'b0;
		req.data   = '0;
		rsp.ready  = 1'b0;
		burst_left = 0;
		sent       = 0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		issue(fixed_request(ACT_POP, 32'h1234_5678, 16'hBEEF));
		issue(fixed_request(ACT_INSERT, 32'h0, 16'h0001));
		issue(fixed_request(ACT_INSERT, 32'h7FFF_FFFF, 16'hFFFF));
		issue(fixed_request(ACT_INSERT, 32'h8000_0000, 16'h0000));
		issue(fixed_request(ACT_INSERT, 32'h0, 16'h0002));
		issue(fixed_request(ACT_INSERT, 32'hFFFF_FFFF, 16'h0003));
		issue(fixed_request(ACT_INSERT, 32'h0, 16'h0004));
		issue(fixed_request(ACT_INSERT, 32'h7FFF_FFFF, 16'h5555));
		issue(fixed_request(ACT_INSERT, 32'h8000_0000, 16'hAAAA));
		issue(fixed_request(ACT_INSERT, 32'h0000_0001, 16'h0005));
		repeat (10) issue(make_request(1'b1));
		issue(fixed_request(ACT_POP, 32'hFFFF_FFFF, 16'hFFFF));

		// fill, drain, mixed and noisy stretches; fill runs reach the full case
		while (sent < 800) begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(20, 90);
			case (mode)
				0: pop_pct = 10;
				1: pop_pct = 85;
				2: pop_pct = 50;
				default: pop_pct = $urandom_range(0, 100);
			endcase
			repeat (seg) issue(make_request($urandom_range(0, 99) < pop_pct));
		end

		@(negedge clk);
		req.valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (4) @(posedge clk);

		$display("sent %0d requests: %0d pops served, %0d pops on empty, %0d inserts dropped",
		         sent, served, empties, drops);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
